>>> src/bfdp_pkg.sv
`default_nettype none
package bfdp_pkg;

	localparam int LANES  = 16;
	localparam int LW     = $clog2(LANES);
	localparam int QDEPTH = 4;
	localparam int QW     = $clog2(QDEPTH);

	typedef struct packed {
		logic              sgn;
		logic              inf;
		logic              nan;
		logic signed [9:0] exp;
		logic [15:0]       mag;
		logic              beat_end;
		logic              last;
	} lane_t;

endpackage
`default_nettype wire

>>> src/bfdp_front.sv
`default_nettype none
module bfdp_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic [15:0]    weight,
	input  wire logic [15:0]    activation,
	input  wire logic           last,
	input  wire logic           pair_valid,
	output logic                pair_stall,
	input  wire logic           full,
	output logic                push,
	output bfdp_pkg::lane_t     lane
);
	import bfdp_pkg::*;

	logic [LW-1:0] cnt_q;
	logic [7:0] ae, be;
	logic [6:0] af, bf;
	logic anorm, bnorm, asub, bsub, azero, bzero, ainf, binf, anan, bnan;
	logic cn, ci, cz;
	logic [7:0] ma, mb;
	logic signed [9:0] er;
	logic beat_end;

	always_comb begin
		ae = weight[14:7];
		af = weight[6:0];
		be = activation[14:7];
		bf = activation[6:0];
		anorm = (ae != 8'd0) && (ae != 8'd255);
		bnorm = (be != 8'd0) && (be != 8'd255);
		asub = (ae == 8'd0) && (af != 7'd0);
		bsub = (be == 8'd0) && (bf != 7'd0);
		azero = (ae == 8'd0) && (af == 7'd0);
		bzero = (be == 8'd0) && (bf == 7'd0);
		ainf = (ae == 8'd255) && (af == 7'd0);
		binf = (be == 8'd255) && (bf == 7'd0);
		anan = (ae == 8'd255) && (af != 7'd0);
		bnan = (be == 8'd255) && (bf != 7'd0);
		ma = {anorm, af};
		mb = {bnorm, bf};
		er = $signed({2'b00, (asub ? 8'd1 : ae)}) + $signed({2'b00, (bsub ? 8'd1 : be)})
			- 10'sd127;
		cn = anan || bnan || (azero && binf) || (ainf && bzero);
		ci = !cn && (ainf || binf);
		cz = !cn && !ci && (azero || bzero);
		beat_end = (cnt_q == LW'(LANES - 1)) || last;
		lane.sgn = weight[15] ^ activation[15];
		lane.inf = ci;
		lane.nan = cn;
		lane.exp = (cn || ci || cz) ? 10'sd0 : er;
		lane.mag = (cn || ci || cz) ? 16'd0 : (ma * mb);
		lane.beat_end = beat_end;
		lane.last = last;
	end

	assign pair_stall = full;
	assign push = pair_valid && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (push) begin
			cnt_q <= beat_end ? '0 : cnt_q + 1'b1;
		end
	end

endmodule
`default_nettype wire

>>> src/bfdp_fifo.sv
`default_nettype none
module bfdp_fifo (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire bfdp_pkg::lane_t  wr_data,
	input  wire logic             rd_en,
	output bfdp_pkg::lane_t       rd_data,
	output logic                  full,
	output logic                  empty
);
	import bfdp_pkg::*;

	lane_t mem_q [QDEPTH];
	logic [QW-1:0] wptr_q, rptr_q;
	logic [QW:0] count_q;

	assign full = (count_q == (QW+1)'(QDEPTH));
	assign empty = (count_q == '0);
	assign rd_data = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			count_q <= '0;
		end else begin
			if (wr_en) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (rd_en) begin
				rptr_q <= rptr_q + 1'b1;
			end
			count_q <= count_q + (QW+1)'(wr_en) - (QW+1)'(rd_en);
		end
	end

endmodule
`default_nettype wire

>>> src/bfdp_back.sv
`default_nettype none
module bfdp_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire bfdp_pkg::lane_t  q,
	input  wire logic             empty,
	output logic                  pop,
	output logic [15:0]           result,
	output logic                  result_valid,
	input  wire logic             result_stall
);
	import bfdp_pkg::*;

	typedef enum logic [6:0] {
		COLL  = 7'b0000001,
		SUM   = 7'b0000010,
		NORM  = 7'b0000100,
		ALIGN = 7'b0001000,
		ROUND = 7'b0010000,
		UPD   = 7'b0100000,
		OUTW  = 7'b1000000
	} state_t;

	function automatic logic [4:0] msb28(input logic [27:0] v);
		logic [4:0] p;
		p = 5'd0;
		for (int i = 0; i < 28; i++) begin
			if (v[i]) p = 5'(i);
		end
		return p;
	endfunction

	state_t state_q;
	logic [LW-1:0] cnt_q, idx_q;
	logic [LW:0] nl_q;
	logic lane_sgn_q [LANES];
	logic signed [9:0] lane_exp_q [LANES];
	logic [15:0] lane_mag_q [LANES];
	logic signed [9:0] mx_q;
	logic anyn_q, anyp_q, anyneg_q, last_q;
	logic [28:0] sum_q;
	logic nsign_q, nzero_q;
	logic [23:0] nman_q;
	logic signed [9:0] nexp_q;
	logic signed [28:0] ssum_q;
	logic signed [9:0] bexp_q;
	logic ssign_q, szero_q;
	logic [23:0] rman_q;
	logic signed [9:0] rexp_q;
	logic acc_sign_q, acc_inf_q, acc_nan_q, acc_inf_sign_q;
	logic signed [9:0] acc_exp_q;
	logic [23:0] acc_man_q;
	logic [15:0] result_q;
	logic res_valid_q;

	logic first, padded;
	logic signed [9:0] mx_new, mx_fin;
	logic anyn_new, anyp_new, anyneg_new;
	logic signed [10:0] sh;
	logic [23:0] mag;
	logic [28:0] nabs;
	logic [4:0] np;
	logic nallz;
	logic signed [9:0] shamt, nexp;
	logic [51:0] nsh;
	logic b_nan, b_inf, b_inf_s;
	logic pse, nse, fnan, finf, finfs;
	logic pzero, nzeff, psub;
	logic signed [9:0] eeff, bexpv;
	logic signed [11:0] diff, ad;
	logic pbig, aovf;
	logic [4:0] ash;
	logic [23:0] big, sml;
	logic bsn, ssn;
	logic [50:0] sh51;
	logic [26:0] ali, big27;
	logic signed [28:0] sum29, tb, ts;
	logic [28:0] absv;
	logic [27:0] abs28;
	logic szero, ssign;
	logic [4:0] lz;
	logic [54:0] n55;
	logic [26:0] n27;
	logic signed [9:0] rpre, rexp;
	logic rup, rcy;
	logic [24:0] r25;
	logic [23:0] rman;
	logic us, uz;
	logic signed [9:0] ue, sam;
	logic [23:0] um;
	logic upd_sign, upd_inf, upd_nan, upd_inf_sign;
	logic signed [9:0] upd_exp;
	logic [23:0] upd_man;
	logic brup, bcy;
	logic [8:0] bs;
	logic [6:0] bfr;
	logic signed [9:0] be;
	logic bsg;
	logic [15:0] bf16;
	logic out_free;

	always_comb begin
		first = (cnt_q == '0);
		mx_new = (first || (q.exp > mx_q)) ? q.exp : mx_q;
		anyn_new = (!first && anyn_q) || q.nan;
		anyp_new = (!first && anyp_q) || (q.inf && !q.sgn);
		anyneg_new = (!first && anyneg_q) || (q.inf && q.sgn);
		padded = (cnt_q != LW'(LANES - 1));
		mx_fin = (padded && (mx_new < 10'sd0)) ? 10'sd0 : mx_new;

		sh = {mx_q[9], mx_q} - {lane_exp_q[idx_q][9], lane_exp_q[idx_q]};
		mag = (sh > 11'sd23) ? 24'd0 : ({lane_mag_q[idx_q], 8'd0} >> sh[4:0]);

		nabs = sum_q[28] ? (~sum_q + 29'd1) : sum_q;
		nallz = (nabs[27:0] == 28'd0);
		np = nallz ? 5'd0 : msb28(nabs[27:0]);
		shamt = nallz ? 10'sd0 : ($signed({5'd0, np}) - 10'sd23);
		nsh = {nabs, 23'd0} >> np;
		nexp = mx_q + shamt + 10'sd1;

		b_nan = anyn_q || (anyp_q && anyneg_q);
		b_inf = (anyp_q || anyneg_q) && !b_nan;
		b_inf_s = b_nan ? 1'b0 : !anyp_q;
		pse = acc_inf_q ? acc_inf_sign_q : acc_sign_q;
		nse = b_inf ? b_inf_s : nsign_q;
		fnan = acc_nan_q || b_nan || (acc_inf_q && b_inf && (pse != nse));
		finf = (acc_inf_q || b_inf) && !fnan;
		finfs = fnan ? 1'b0 : (acc_inf_q ? pse : nse);
		pzero = (acc_man_q == 24'd0) && !acc_inf_q && !acc_nan_q;
		nzeff = nzero_q && !b_inf && !b_nan;
		psub = (acc_exp_q == 10'sd0) && (acc_man_q != 24'd0) && !acc_inf_q && !acc_nan_q;
		eeff = psub ? 10'sd1 : acc_exp_q;

		diff = {{2{eeff[9]}}, eeff} - {{2{nexp_q[9]}}, nexp_q};
		pbig = !diff[11];
		ad = pbig ? diff : -diff;
		aovf = ad > 12'sd27;
		ash = aovf ? 5'd27 : ad[4:0];
		big = pbig ? acc_man_q : nman_q;
		sml = pbig ? nman_q : acc_man_q;
		bsn = pbig ? acc_sign_q : nsign_q;
		ssn = pbig ? nsign_q : acc_sign_q;
		bexpv = pbig ? eeff : nexp_q;
		sh51 = {sml, 27'd0} >> ash;
		ali = sh51[50:24];
		if ((sh51[23:0] != 24'd0) || (aovf && (sml != 24'd0))) ali[0] = 1'b1;
		big27 = {big, 3'd0};
		tb = $signed({2'b00, big27});
		ts = $signed({2'b00, ali});
		sum29 = (bsn ? -tb : tb) + (ssn ? -ts : ts);

		ssign = ssum_q[28];
		absv = ssign ? 29'(-ssum_q) : 29'(ssum_q);
		abs28 = absv[27:0];
		szero = (abs28 == 28'd0);
		lz = szero ? 5'd0 : msb28(abs28);
		n55 = {abs28, 27'd0} >> ({1'b0, lz} + 6'd1);
		n27 = n55[26:0];
		if (lz == 5'd27) n27[0] = n27[0] | abs28[0];
		rpre = bexp_q + $signed({5'd0, lz}) - 10'sd26;
		rup = n27[2] && (n27[1] || n27[0] || n27[3]);
		r25 = {1'b0, n27[26:3]} + {24'd0, rup};
		rcy = r25[24];
		rman = rcy ? r25[24:1] : r25[23:0];
		rexp = rcy ? (rpre + 10'sd1) : rpre;

		uz = 1'b0;
		if (pzero && nzeff) begin
			us = 1'b0; ue = 10'sd0; um = 24'd0; uz = 1'b1;
		end else if (pzero) begin
			us = nsign_q; ue = nexp_q; um = nman_q;
		end else if (nzeff) begin
			us = acc_sign_q; ue = acc_exp_q; um = acc_man_q;
		end else if (szero_q) begin
			us = 1'b0; ue = 10'sd0; um = 24'd0; uz = 1'b1;
		end else begin
			us = ssign_q; ue = rexp_q; um = rman_q;
		end
		sam = 10'sd1 - ue;

		upd_sign = 1'b0;
		upd_exp = 10'sd0;
		upd_man = 24'd0;
		upd_inf = 1'b0;
		upd_nan = 1'b0;
		upd_inf_sign = 1'b0;
		if (fnan) begin
			upd_nan = 1'b1;
		end else if (finf) begin
			upd_sign = finfs;
			upd_exp = 10'sd255;
			upd_inf = 1'b1;
			upd_inf_sign = finfs;
		end else if (!uz) begin
			if (ue > 10'sd254) begin
				upd_sign = us;
				upd_exp = 10'sd255;
				upd_inf = 1'b1;
				upd_inf_sign = us;
			end else if (ue >= 10'sd1) begin
				upd_sign = us;
				upd_exp = ue;
				upd_man = um;
			end else if (ue >= -10'sd22) begin
				upd_sign = us;
				upd_man = um >> sam[4:0];
			end
		end

		bsg = acc_inf_q ? acc_inf_sign_q : acc_sign_q;
		brup = acc_man_q[15] && (acc_man_q[16] || (acc_man_q[14:0] != 15'd0));
		bs = {1'b0, acc_man_q[23:16]} + {8'd0, brup};
		bcy = acc_man_q[23] ? bs[8] : bs[7];
		bfr = bcy ? 7'd0 : bs[6:0];
		be = acc_exp_q + $signed({9'd0, bcy});
		if (acc_nan_q) bf16 = 16'h7FC0;
		else if (acc_inf_q) bf16 = {bsg, 8'hFF, 7'd0};
		else if (acc_man_q == 24'd0) bf16 = {bsg, 15'd0};
		else if (be > 10'sd254) bf16 = {bsg, 8'hFF, 7'd0};
		else bf16 = {bsg, be[7:0], bfr};

		out_free = !res_valid_q || !result_stall;
		pop = (state_q == COLL) && !empty;
	end

	assign result = result_q;
	assign result_valid = res_valid_q;

	always_ff @(posedge clk) begin
		if (pop) begin
			lane_sgn_q[cnt_q] <= q.sgn;
			lane_exp_q[cnt_q] <= q.exp;
			lane_mag_q[cnt_q] <= q.mag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= COLL;
			cnt_q <= '0;
			idx_q <= '0;
			nl_q <= '0;
			mx_q <= '0;
			anyn_q <= 1'b0;
			anyp_q <= 1'b0;
			anyneg_q <= 1'b0;
			last_q <= 1'b0;
			sum_q <= '0;
			nsign_q <= 1'b0;
			nzero_q <= 1'b0;
			nman_q <= '0;
			nexp_q <= '0;
			ssum_q <= '0;
			bexp_q <= '0;
			ssign_q <= 1'b0;
			szero_q <= 1'b0;
			rman_q <= '0;
			rexp_q <= '0;
			acc_sign_q <= 1'b0;
			acc_inf_q <= 1'b0;
			acc_nan_q <= 1'b0;
			acc_inf_sign_q <= 1'b0;
			acc_exp_q <= '0;
			acc_man_q <= '0;
			result_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (res_valid_q && !result_stall && (state_q != OUTW)) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				COLL: begin
					if (pop) begin
						anyn_q <= anyn_new;
						anyp_q <= anyp_new;
						anyneg_q <= anyneg_new;
						if (q.beat_end) begin
							mx_q <= mx_fin;
							nl_q <= {1'b0, cnt_q} + 1'b1;
							last_q <= q.last;
							cnt_q <= '0;
							idx_q <= '0;
							sum_q <= '0;
							state_q <= SUM;
						end else begin
							mx_q <= mx_new;
							cnt_q <= cnt_q + 1'b1;
						end
					end
				end
				SUM: begin
					sum_q <= lane_sgn_q[idx_q] ? (sum_q - {5'd0, mag}) : (sum_q + {5'd0, mag});
					idx_q <= idx_q + 1'b1;
					if ({1'b0, idx_q} == nl_q - 1'b1) begin
						state_q <= NORM;
					end
				end
				NORM: begin
					nsign_q <= sum_q[28];
					nman_q <= nsh[23:0];
					nexp_q <= nexp;
					nzero_q <= (nabs == 29'd0);
					state_q <= ALIGN;
				end
				ALIGN: begin
					ssum_q <= sum29;
					bexp_q <= bexpv;
					state_q <= ROUND;
				end
				ROUND: begin
					ssign_q <= ssign;
					szero_q <= szero;
					rman_q <= rman;
					rexp_q <= rexp;
					state_q <= UPD;
				end
				UPD: begin
					acc_sign_q <= upd_sign;
					acc_exp_q <= upd_exp;
					acc_man_q <= upd_man;
					acc_inf_q <= upd_inf;
					acc_nan_q <= upd_nan;
					acc_inf_sign_q <= upd_inf_sign;
					state_q <= last_q ? OUTW : COLL;
				end
				OUTW: begin
					if (out_free) begin
						result_q <= bf16;
						res_valid_q <= 1'b1;
						acc_sign_q <= 1'b0;
						acc_exp_q <= 10'sd0;
						acc_man_q <= 24'd0;
						acc_inf_q <= 1'b0;
						acc_nan_q <= 1'b0;
						acc_inf_sign_q <= 1'b0;
						state_q <= COLL;
					end
				end
				default: begin
					state_q <= COLL;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

>>> src/bf16_block_fp_dot_product.sv
// bf16 dot product with block floating point accumulation.
// Request channel: weight, activation and last, taken when pair_valid is
// high and pair_stall low. Each request carries one bf16 pair; last closes
// the vector. Result channel: result (bf16) with result_valid and
// result_stall, one result per vector.
// The front forms the exact lane product as each request arrives and pushes
// it into a four entry queue, so requests enter one per cycle while the
// queue has room. The back drains the queue a beat of up to 16 lanes at a
// time: it collects the lanes, passes them one by one through the shared
// align and add unit, then normalizes, aligns, rounds and folds the beat
// into the accumulator in the NORM, ALIGN, ROUND and UPD states. After the
// last beat of a vector is folded, the back moves to OUTW and registers the
// result there once the output register is free.
// A stalled result holds in the output register; the back waits before
// writing the next result, and the queue then fills and raises pair_stall.
// Reset clears the accumulator, lane count, queue and output valid.
`default_nettype none
module bf16_block_fp_dot_product (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [15:0] weight,
	input  wire logic [15:0] activation,
	input  wire logic        last,
	input  wire logic        pair_valid,
	output logic             pair_stall,
	output logic [15:0]      result,
	output logic             result_valid,
	input  wire logic        result_stall
);
	import bfdp_pkg::*;

	lane_t lane_in, lane_out;
	logic push, pop, full, empty;

	bfdp_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.weight(weight),
		.activation(activation),
		.last(last),
		.pair_valid(pair_valid),
		.pair_stall(pair_stall),
		.full(full),
		.push(push),
		.lane(lane_in)
	);

	bfdp_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(push),
		.wr_data(lane_in),
		.rd_en(pop),
		.rd_data(lane_out),
		.full(full),
		.empty(empty)
	);

	bfdp_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q(lane_out),
		.empty(empty),
		.pop(pop),
		.result(result),
		.result_valid(result_valid),
		.result_stall(result_stall)
	);

endmodule
`default_nettype wire

>>> tb/bf16_block_fp_dot_product_tb.sv
module bf16_block_fp_dot_product_tb;

	localparam int NLANES = 16;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [15:0] w;
		logic [15:0] x;
		logic        lst;
	} pair_req_t;

	logic        clk;
	logic        arst_n;
	logic [15:0] weight;
	logic [15:0] activation;
	logic        last;
	logic        pair_valid;
	logic        pair_stall;
	logic [15:0] result;
	logic        result_valid;
	logic        result_stall;

	pair_req_t   pending_q[$];
	logic [15:0] dot_q[$];
	int          err_cnt = 0;
	int          cycle_cnt = 0;
	int          vec_cnt = 0;
	int          res_cnt = 0;
	bit          stim_done = 0;
	int          burst_left = 0;
	int          gap_left = 0;
	int          stall_mode = 0;

	logic [31:0]        beat_pairs[NLANES];
	int                 beat_fill;
	logic               acc_s;
	logic signed [11:0] acc_e;
	logic [23:0]        acc_m;
	logic               acc_inf, acc_nan, acc_infs;

	bf16_block_fp_dot_product u_top (
		.clk(clk), .arst_n(arst_n), .weight(weight), .activation(activation),
		.last(last), .pair_valid(pair_valid), .pair_stall(pair_stall),
		.result(result), .result_valid(result_valid), .result_stall(result_stall)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic longint wrap10(longint v);
		longint r;
		r = v & 'h3FF;
		if (r >= 'h200) r = r - 'h400;
		return r;
	endfunction

	function automatic int top_bit(longint v);
		int p;
		p = 0;
		while (v > 1) begin
			v = v >> 1;
			p++;
		end
		return p;
	endfunction

	task automatic acc_clear();
		acc_s = 0; acc_e = 0; acc_m = 0; acc_inf = 0; acc_nan = 0; acc_infs = 0;
	endtask

	task automatic fold_beat();
		logic        ls[NLANES], linf[NLANES], lnan[NLANES];
		longint      le[NLANES];
		longint      lm[NLANES];
		logic [31:0] p;
		logic [15:0] a, b;
		int          ae, af, be, bf, i, lz;
		bit          anorm, bnorm, asub, bsub, azero, bzero, ainf, binf, anan, bnan;
		bit          cn, ci, cz, anyn, anyp, anyneg, bnan_b, binf_b, binfs;
		bit          nsign, allz, nzero, fnan, finf, finfs, pzero, nzeff, psub;
		bit          pbig, aovf, ssign, szero, uz, us, rcy;
		longint      mx, s, sh, mag, msum, nabs, m28, shamt, rsh, nman, nexp;
		longint      pse, nse, eeff, diff, ad, big, sml, bexp, ash, sh51, ali;
		longint      big27, sum, abs28, n27, rpre, rup, r25, rman, rexp, ue, um;
		bit          bsn, ssn;
		for (i = 0; i < NLANES; i++) begin
			p = (i < beat_fill) ? beat_pairs[i] : 32'h0;
			a = p[31:16]; b = p[15:0];
			ae = int'(a[14:7]); af = int'(a[6:0]); be = int'(b[14:7]); bf = int'(b[6:0]);
			anorm = ae != 0 && ae != 255; bnorm = be != 0 && be != 255;
			asub = ae == 0 && af != 0; bsub = be == 0 && bf != 0;
			azero = ae == 0 && af == 0; bzero = be == 0 && bf == 0;
			ainf = ae == 255 && af == 0; binf = be == 255 && bf == 0;
			anan = ae == 255 && af != 0; bnan = be == 255 && bf != 0;
			cn = anan || bnan || (azero && binf) || (ainf && bzero);
			ci = !cn && (ainf || binf);
			cz = !cn && !ci && (azero || bzero);
			ls[i] = a[15] ^ b[15];
			le[i] = (cn || ci || cz) ? 0 :
				longint'(asub ? 1 : ae) + longint'(bsub ? 1 : be) - 127;
			lm[i] = (cn || ci || cz) ? 0 :
				((longint'(anorm) * 128 + af) * (longint'(bnorm) * 128 + bf)) & 'hFFFF;
			linf[i] = ci; lnan[i] = cn;
		end
		mx = le[0]; anyn = 0; anyp = 0; anyneg = 0;
		for (i = 0; i < NLANES; i++) begin
			if (le[i] > mx) mx = le[i];
			if (lnan[i]) anyn = 1;
			if (linf[i] && !ls[i]) anyp = 1;
			if (linf[i] && ls[i]) anyneg = 1;
		end
		bnan_b = anyn || (anyp && anyneg);
		binf_b = (anyp || anyneg) && !bnan_b;
		binfs = bnan_b ? 1'b0 : !anyp;
		s = 0;
		for (i = 0; i < NLANES; i++) begin
			sh = mx - le[i];
			mag = (sh >= 24) ? 0 : ((lm[i] << 8) >> sh);
			s += ls[i] ? -mag : mag;
		end
		msum = s & 'h1FFFFFFF;
		nsign = msum[28];
		nabs = nsign ? ((~msum + 1) & 'h1FFFFFFF) : msum;
		m28 = nabs & 'hFFFFFFF;
		allz = m28 == 0;
		shamt = allz ? 0 : top_bit(m28) - 23;
		rsh = (23 + shamt) & 'h3F;
		nman = ((nabs << 23) >> rsh) & 'hFFFFFF;
		nexp = wrap10(mx + shamt + 1);
		nzero = nabs == 0;
		pse = acc_inf ? acc_infs : acc_s;
		nse = binf_b ? binfs : nsign;
		fnan = acc_nan || bnan_b || (acc_inf && binf_b && pse != nse);
		finf = (acc_inf || binf_b) && !fnan;
		finfs = fnan ? 1'b0 : (acc_inf ? pse[0] : nse[0]);
		pzero = acc_m == 0 && !acc_inf && !acc_nan;
		nzeff = nzero && !binf_b && !bnan_b;
		psub = acc_e == 0 && acc_m != 0 && !acc_inf && !acc_nan;
		eeff = psub ? 1 : longint'(acc_e);
		diff = eeff - nexp;
		pbig = diff >= 0;
		ad = pbig ? diff : -diff;
		big = pbig ? longint'(acc_m) : nman;
		sml = pbig ? nman : longint'(acc_m);
		bsn = pbig ? acc_s : nsign;
		ssn = pbig ? nsign : acc_s;
		bexp = pbig ? eeff : nexp;
		aovf = ad > 27;
		ash = aovf ? 27 : ad;
		sh51 = (sml << 27) >> ash;
		ali = (sh51 >> 24) & 'h7FFFFFF;
		if ((sh51 & 'hFFFFFF) != 0 || (aovf && sml != 0)) ali = ali | 1;
		big27 = (big << 3) & 'h7FFFFFF;
		sum = (bsn ? -big27 : big27) + (ssn ? -ali : ali);
		ssign = sum < 0;
		abs28 = (ssign ? -sum : sum) & 'hFFFFFFF;
		szero = abs28 == 0;
		lz = szero ? 0 : top_bit(abs28);
		n27 = ((abs28 << 27) >> (lz + 1)) & 'h7FFFFFF;
		if (lz == 27) n27 = n27 | (abs28 & 1);
		rpre = wrap10(bexp + lz - 26);
		rup = ((n27 >> 2) & 1) & (((n27 >> 1) | n27 | (n27 >> 3)) & 1);
		r25 = ((n27 >> 3) & 'hFFFFFF) + rup;
		rcy = r25[24];
		rman = rcy ? ((r25 >> 1) & 'hFFFFFF) : (r25 & 'hFFFFFF);
		rexp = wrap10(rcy ? rpre + 1 : rpre);
		uz = 0;
		if (pzero && nzeff) begin
			us = 0; ue = 0; um = 0; uz = 1;
		end else if (pzero) begin
			us = nsign; ue = nexp; um = nman;
		end else if (nzeff) begin
			us = acc_s; ue = longint'(acc_e); um = longint'(acc_m);
		end else if (szero) begin
			us = 0; ue = 0; um = 0; uz = 1;
		end else begin
			us = ssign; ue = rexp; um = rman;
		end
		acc_clear();
		if (fnan) begin
			acc_nan = 1;
		end else if (finf) begin
			acc_s = finfs; acc_e = 255; acc_inf = 1; acc_infs = finfs;
		end else if (uz) begin
		end else if (ue > 254) begin
			acc_s = us; acc_e = 255; acc_inf = 1; acc_infs = us;
		end else if (ue >= 1) begin
			acc_s = us; acc_e = 12'(ue); acc_m = 24'(um);
		end else if (ue >= -22) begin
			acc_s = us;
			acc_m = 24'((um >> ((1 - ue) & 'h1F)) & 'hFFFFFF);
		end
	endtask

	function automatic logic [15:0] acc_to_bf16();
		logic   sg;
		longint m, rup, bs, cy, fr, e;
		sg = acc_inf ? acc_infs : acc_s;
		m = longint'(acc_m);
		rup = ((m >> 15) & 1) & (((m >> 16) & 1) | ((m & 'h7FFF) != 0));
		bs = ((m >> 16) & 'hFF) + rup;
		cy = ((m >> 23) & 1) ? ((bs >> 8) & 1) : ((bs >> 7) & 1);
		fr = cy ? 0 : (bs & 'h7F);
		e = wrap10(longint'(acc_e) + cy);
		if (acc_nan) return 16'h7FC0;
		if (acc_inf) return {sg, 8'hFF, 7'h0};
		if (m == 0) return {sg, 15'h0};
		if (e > 254) return {sg, 8'hFF, 7'h0};
		return {sg, e[7:0], fr[6:0]};
	endfunction

	task automatic predict_pair(pair_req_t r);
		if (beat_fill < NLANES) beat_pairs[beat_fill] = {r.w, r.x};
		beat_fill++;
		if (beat_fill >= NLANES || r.lst) begin
			fold_beat();
			beat_fill = 0;
		end
		if (r.lst) begin
			dot_q.push_back(acc_to_bf16());
			acc_clear();
			vec_cnt++;
		end
	endtask

	function automatic logic [15:0] rand_bf16();
		logic [15:0] v;
		int          k;
		v = 16'($urandom);
		k = $urandom_range(0, 15);
		case (k)
			0: v[14:0] = 0;
			1: v[14:7] = 0;
			2: v[14:0] = 15'h7F80;
			3: v[14:7] = 8'hFF;
			4: v[14:7] = 8'($urandom_range(1, 20));
			5: v[14:7] = 8'($urandom_range(235, 254));
			default: v[14:7] = 8'($urandom_range(110, 140));
		endcase
		return v;
	endfunction

	task automatic add_pair(logic [15:0] w, logic [15:0] x, logic l);
		pair_req_t r;
		r.w = w; r.x = x; r.lst = l;
		pending_q.push_back(r);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_valid <= 0;
			weight <= 0;
			activation <= 0;
			last <= 0;
		end else begin
			if (pair_valid && !pair_stall) begin
				predict_pair({weight, activation, last});
				void'(pending_q.pop_front());
			end
			if (pair_valid && pair_stall) begin
			end else if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				pair_valid <= 0;
			end else if ((pair_valid && !pair_stall ? pending_q.size() > 0 :
					pending_q.size() > 0)) begin
				pair_valid <= 1;
				weight <= pending_q[0].w;
				activation <= pending_q[0].x;
				last <= pending_q[0].lst;
				if (burst_left > 0) begin
					burst_left <= burst_left - 1;
				end else begin
					burst_left <= $urandom_range(0, 40);
					gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end
			end else begin
				pair_valid <= 0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 0;
		end else begin
			cycle_cnt <= cycle_cnt + 1;
			if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
			case (stall_mode)
				0: result_stall <= 0;
				1: result_stall <= $urandom_range(0, 3) == 0;
				2: result_stall <= 1'($urandom_range(0, 1));
				default: result_stall <= $urandom_range(0, 9) != 0;
			endcase
			if (result_valid && !result_stall) begin
				res_cnt++;
				if (dot_q.size() == 0) begin
					$error("unexpected result %h", result);
					err_cnt++;
				end else begin
					if (result !== dot_q[0]) begin
						$error("result: expected %h, actual %h", dot_q[0], result);
						err_cnt++;
					end
					void'(dot_q.pop_front());
				end
			end
		end
	end

	initial begin
		int n, i, len;
		beat_fill = 0;
		acc_clear();
		arst_n = 0;
		add_pair(16'h3F80, 16'h3F80, 1);
		add_pair(16'h7F7F, 16'h7F7F, 1);
		add_pair(16'hFFFF, 16'h0000, 1);
		add_pair(16'h0000, 16'h7F80, 1);
		add_pair(16'h7F80, 16'h3F80, 0);
		add_pair(16'hFF80, 16'h3F80, 1);
		add_pair(16'h0001, 16'h3F80, 1);
		add_pair(16'h0001, 16'h0001, 1);
		add_pair(16'h7F80, 16'h4000, 0);
		add_pair(16'hC000, 16'h7F80, 1);
		add_pair(16'h3F80, 16'h3F80, 0);
		add_pair(16'hBF80, 16'h3F80, 1);
		for (i = 0; i < 17; i++) add_pair(16'h7F00, 16'h7F00, i == 16);
		add_pair(16'h8001, 16'h807F, 1);
		n = 29;
		while (n < 1250) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 50) : $urandom_range(1, 20);
			for (i = 0; i < len; i++) add_pair(rand_bf16(), rand_bf16(), i == len - 1);
			n += len;
		end
		repeat (9) @(posedge clk);
		arst_n <= 1;
		wait (pending_q.size() == 0 && dot_q.size() == 0);
		repeat (80) @(posedge clk);
		$display("Ran %0d vectors, %0d results checked, %0d cycles.", vec_cnt, res_cnt,
			cycle_cnt);
		if (err_cnt == 0) $display("Testbench completed without errors");
		else $display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		wait (cycle_cnt >= CYCLE_LIMIT);
		$display("Timeout after %0d cycles", cycle_cnt);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

>>> filelist.f
src/bfdp_pkg.sv
src/bfdp_front.sv
src/bfdp_fifo.sv
src/bfdp_back.sv
src/bf16_block_fp_dot_product.sv
tb/bf16_block_fp_dot_product_tb.sv
